// ===== rtl/usspf_pkg.sv =====
// Shared constants, types and a helper function for the UTF-8 substring position finder.
package usspf_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int PATTERN_BYTES     = 16;
  localparam int PATTERN_WORDS     = 4;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 32;
  localparam int PAT_LEN_BITS      = 5;
  localparam int START_POS_BITS    = 16;
  localparam int RESULT_POS_BITS   = 16;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3,
    REG_PATTERN_LENGTH,
    REG_START_POSITION
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       is_start;
  } byte_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Continuation bytes that follow a lead byte; anything else is a one-byte character.
  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] n;
    if (b[7:5] == 3'b110) begin
      n = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      n = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

// ===== rtl/usspf_ifs.sv =====
// Channel interfaces: text byte requests, result requests and configuration writes.
interface usspf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface usspf_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] position;
  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

interface usspf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/usspf_front.sv =====
// Front end: accepts text bytes, finds character boundaries and numbers characters.
module usspf_front import usspf_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  usspf_text_if.sink               text,
  input  logic                     push_ready,
  output logic                     push_valid,
  output byte_item_t               item,
  output logic [POSITION_BITS-1:0] pos
);

  logic [1:0]               left;
  logic [1:0]               left_next;
  logic [POSITION_BITS-1:0] counter;
  logic [POSITION_BITS-1:0] counter_next;
  logic                     is_start;
  logic                     accept;

  assign text.ready = push_ready;
  assign push_valid = text.valid;
  assign accept     = text.valid && push_ready;

  always_comb begin
    if (left == 2'd0) begin
      is_start     = 1'b1;
      counter_next = (counter == '1) ? counter : counter + 1'b1;
      left_next    = lead_extra(text.text_byte);
    end else begin
      is_start     = 1'b0;
      counter_next = counter;
      left_next    = left - 2'd1;
    end
  end

  assign item.text_byte = text.text_byte;
  assign item.last_byte = text.last_byte;
  assign item.is_start  = is_start;
  assign pos            = counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      left    <= 2'd0;
      counter <= '0;
    end else if (accept) begin
      if (text.last_byte) begin
        left    <= 2'd0;
        counter <= '0;
      end else begin
        left    <= left_next;
        counter <= counter_next;
      end
    end
  end

endmodule

// ===== rtl/usspf_queue.sv =====
// Two-entry queue between the front end and the matcher.
module usspf_queue import usspf_pkg::*; #(
  parameter int W = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [W-1:0]  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [W-1:0]  pop_data,
  output queue_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign pop_data     = mem[rd_ptr];
  assign push         = push_valid && push_ready;
  assign pop          = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/usspf_back.sv =====
// Back end: byte window, parallel pattern compare, first-match capture and result register.
module usspf_back import usspf_pkg::*; #(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  byte_item_t                    item,
  input  logic [POSITION_BITS-1:0]      in_pos,
  input  logic [8*PATTERN_BYTES-1:0]    pattern,
  input  logic [PAT_LEN_BITS-1:0]       pattern_length,
  input  logic [START_POS_BITS-1:0]     start_position,
  usspf_result_if.source                result
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (POSITION_BITS > START_POS_BITS) ? POSITION_BITS : START_POS_BITS;

  logic [7:0]               win_byte [PATTERN_MAX];
  logic                     win_start [PATTERN_MAX];
  logic [POSITION_BITS-1:0] win_pos [PATTERN_MAX];
  logic [7:0]               byte_next [PATTERN_MAX];
  logic                     start_next [PATTERN_MAX];
  logic [POSITION_BITS-1:0] pos_next [PATTERN_MAX];
  logic [FW-1:0]            fill;
  logic [FW-1:0]            fill_next;
  logic                     seen;
  logic                     seen_next;
  logic [POSITION_BITS-1:0] match_pos;
  logic [POSITION_BITS-1:0] match_pos_next;
  logic                     hit;
  logic [IW-1:0]            base_idx;
  logic                     res_valid;
  logic                     res_found;
  logic [RESULT_POS_BITS-1:0] res_pos;
  logic                     pop;

  assign in_ready = !item.last_byte || !res_valid || result.ready;
  assign pop      = in_valid && in_ready;

  always_comb begin
    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
      byte_next[j]  = win_byte[j+1];
      start_next[j] = win_start[j+1];
      pos_next[j]   = win_pos[j+1];
    end
    byte_next[PATTERN_MAX-1]  = item.text_byte;
    start_next[PATTERN_MAX-1] = item.is_start;
    pos_next[PATTERN_MAX-1]   = in_pos;
    fill_next = (fill == FW'(PATTERN_MAX)) ? fill : fill + 1'b1;
  end

  always_comb begin
    int         base;
    int         k;
    logic       len_ok;
    logic       all_eq;
    logic [7:0] pb;
    len_ok = (pattern_length != '0) && (int'(pattern_length) <= PATTERN_MAX) &&
             (int'(fill_next) >= int'(pattern_length));
    base   = len_ok ? PATTERN_MAX - int'(pattern_length) : 0;
    all_eq = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      k  = j - base;
      pb = 8'd0;
      if (j >= base) begin
        if (k < PATTERN_BYTES) begin
          pb = pattern[k*8 +: 8];
        end
        if (byte_next[j] != pb) begin
          all_eq = 1'b0;
        end
      end
    end
    base_idx = IW'(base);
    hit = !seen && len_ok && all_eq && start_next[base_idx] &&
          (CW'(pos_next[base_idx]) >= CW'(start_position));
    seen_next      = seen || hit;
    match_pos_next = hit ? pos_next[base_idx] : match_pos;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_byte[j]  <= byte_next[j];
        win_start[j] <= start_next[j];
        win_pos[j]   <= pos_next[j];
      end
      match_pos <= match_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      seen <= 1'b0;
    end else if (pop) begin
      if (item.last_byte) begin
        fill <= '0;
        seen <= 1'b0;
      end else begin
        fill <= fill_next;
        seen <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && item.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last_byte) begin
      res_found <= seen_next;
      res_pos   <= seen_next ? RESULT_POS_BITS'(match_pos_next) : '0;
    end
  end

  assign result.valid    = res_valid;
  assign result.found    = res_found;
  assign result.position = res_pos;

endmodule

// ===== rtl/utf8_substring_position_finder_core.sv =====
// UTF-8 substring position finder: top level with configuration registers.
//
// Channels: text takes one byte per request (text_byte, last_byte), result
// delivers one request (found, position) per text, with the final byte.
// cfg writes register index 0..5 (pattern words 0..3, pattern length,
// start position); it is always ready, other indexes are dropped.
// Throughput: one text byte per cycle while the queue has room. The
// front end numbers characters as bytes arrive, a two-entry queue hands
// them to the matcher, which shifts a PATTERN_MAX byte window and
// compares all pattern bytes in parallel. The result is registered.
// When result is stalled the matcher holds the final byte of the next
// text in the queue; bytes before it keep flowing.
// Reset clears the stream state, empties queue and result register, and
// sets pattern words and length to zero and start position to one.
// Positions count from one and saturate at 2^POSITION_BITS - 1.
module utf8_substring_position_finder_core import usspf_pkg::*; #(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  usspf_text_if.sink     text,
  usspf_result_if.source result,
  usspf_cfg_if.sink      cfg
);

  localparam int QW = $bits(byte_item_t) + POSITION_BITS;

  logic [CFG_DATA_BITS-1:0]   pattern_word [PATTERN_WORDS];
  logic [8*PATTERN_BYTES-1:0] pattern;
  logic [PAT_LEN_BITS-1:0]    pattern_length;
  logic [START_POS_BITS-1:0]  start_position;

  logic                     push_valid;
  logic                     push_ready;
  byte_item_t               push_item;
  logic [POSITION_BITS-1:0] push_pos;
  logic                     pop_valid;
  logic                     pop_ready;
  logic [QW-1:0]            pop_data;
  byte_item_t               pop_item;
  logic [POSITION_BITS-1:0] pop_pos;
  queue_status_t            q_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_length <= '0;
      start_position <= START_POS_BITS'(1);
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg.data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg.data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg.data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[PAT_LEN_BITS-1:0];
        REG_START_POSITION: start_position <= cfg.data[START_POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < PATTERN_WORDS; w++) begin
      pattern[w*CFG_DATA_BITS +: CFG_DATA_BITS] = pattern_word[w];
    end
  end

  usspf_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .item       (push_item),
    .pos        (push_pos)
  );

  usspf_queue #(
    .W(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_item, push_pos}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .status     (q_status)
  );

  assign {pop_item, pop_pos} = pop_data;

  usspf_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pop_valid),
    .in_ready       (pop_ready),
    .item           (pop_item),
    .in_pos         (pop_pos),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .start_position (start_position),
    .result         (result)
  );

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.position == '0)
    else $error("result without a match carries a nonzero position");

  a_reset_no_result: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid straight after reset");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_full_blocks_text: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !text.ready)
    else $error("text accepted while the queue is full");

endmodule
